/* design/wihp_pkg.sv */
// Package with shared types, constants and the header length function of the frame parser.
package wihp_pkg;

  localparam int unsigned MaxFrameBytesDef = 4096;
  localparam logic [15:0] DnsPortReset = 16'd53;
  localparam logic [7:0]  LlcSap = 8'haa;
  localparam logic [7:0]  LlcCtrl = 8'h03;
  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoUdp = 8'd17;
  localparam logic [7:0]  ProtoTcp = 8'd6;
  localparam logic [7:0]  ProtoIcmp = 8'd1;
  localparam logic [7:0]  DotChar = 8'h2e;

  localparam logic [0:0] CfgCaptureEnable = 1'b0;
  localparam logic [0:0] CfgDnsPort = 1'b1;

  typedef enum logic [3:0] {
    VerdictDrop     = 4'd0,
    VerdictIcmp     = 4'd1,
    VerdictOtherIp  = 4'd2,
    VerdictUdpShort = 4'd3,
    VerdictUdp      = 4'd4,
    VerdictDns      = 4'd5,
    VerdictDnsQuery = 4'd6,
    VerdictTcpShort = 4'd7,
    VerdictTcp      = 4'd8
  } verdict_e;

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhFirst = 3'd1,
    PhLen   = 3'd2,
    PhChars = 3'd3,
    PhQhi   = 3'd4,
    PhQlo   = 3'd5,
    PhDone  = 3'd6
  } phase_e;

  // One classified byte handed from the front to the back.
  typedef struct packed {
    logic       is_char;
    logic [7:0] name_char;
    logic       is_summary;
  } ev_t;

  // Everything a summary needs, latched at the last byte.
  typedef struct packed {
    logic [3:0]  verdict;
    logic [7:0]  ip_protocol;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] query_type;
  } summary_t;

  function automatic logic [4:0] hdr_len(input logic [15:0] fc);
    logic [4:0] r;
    r = 5'd0;
    if (fc[3:2] == 2'd2) begin
      if (fc[7:4] == 4'd0 || fc[7:4] == 4'd4) r = 5'd24;
      else if (fc[7]) r = 5'd26;
    end
    return r;
  endfunction

endpackage

/* design/wlan_ipv4_header_parser_top.sv */
// Top level of the byte-serial 802.11 IPv4 header parser.
//  channel | signals                            | direction
//  in      | in_valid_i/in_ready_o, frame byte  | into block
//  out     | out_valid_o/out_ready_i, results   | out of block
//  cfg     | cfg_valid_i/cfg_ready_o, idx, data | into block
// One frame byte is taken per cycle while the output queue has room; results are registered into that queue.
// A last byte that also yields a name character or dot gives two items, queued together.
// The front stalls only when the four-entry output queue has fewer than two free slots.
// Reset clears all frame state; capture is disabled and the DNS port is 53.
module wlan_ipv4_header_parser_top #(
  parameter int unsigned MaxFrameBytes = wihp_pkg::MaxFrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        is_data_frame_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        item_kind_o,
  output logic [7:0]  name_char_o,
  output logic [3:0]  verdict_o,
  output logic [7:0]  ip_protocol_o,
  output logic [31:0] source_ip_o,
  output logic [31:0] dest_ip_o,
  output logic [47:0] source_mac_o,
  output logic [47:0] dest_mac_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [7:0]  tcp_flag_bits_o,
  output logic [15:0] query_type_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import wihp_pkg::*;

  logic     cap_en_q;
  logic [15:0] dns_port_q;
  logic     ev_valid, ev_two, room;
  ev_t      ev;
  summary_t sum_in, sum_out;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_en_q <= 1'b0;
      dns_port_q <= DnsPortReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCaptureEnable: cap_en_q <= cfg_data_i[0];
        CfgDnsPort:       dns_port_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wihp_front #(.MaxFrameBytes(MaxFrameBytes)) u_front (
    .clk_i, .rst_ni,
    .in_fire_i(in_valid_i && room),
    .data_byte_i, .last_byte_i, .is_data_frame_i,
    .cap_en_i(cap_en_q), .dns_port_i(dns_port_q),
    .ev_valid_o(ev_valid), .ev_two_o(ev_two), .ev_o(ev), .sum_o(sum_in)
  );

  wihp_back u_back (
    .clk_i, .rst_ni,
    .ev_valid_i(ev_valid), .ev_two_i(ev_two), .ev_i(ev), .sum_i(sum_in),
    .room_o(room), .out_valid_o, .out_ready_i,
    .item_kind_o, .name_char_o, .sum_o(sum_out)
  );

  assign verdict_o = sum_out.verdict;
  assign ip_protocol_o = sum_out.ip_protocol;
  assign source_ip_o = sum_out.source_ip;
  assign dest_ip_o = sum_out.dest_ip;
  assign source_mac_o = sum_out.source_mac;
  assign dest_mac_o = sum_out.dest_mac;
  assign source_port_o = sum_out.source_port;
  assign dest_port_o = sum_out.dest_port;
  assign tcp_flag_bits_o = sum_out.tcp_flag_bits;
  assign query_type_o = sum_out.query_type;

endmodule

/* design/wihp_front.sv */
// Front end: walks the frame byte by byte, captures header fields and builds output items.
module wihp_front #(
  parameter int unsigned MaxFrameBytes = wihp_pkg::MaxFrameBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic               is_data_frame_i,
  input  logic               cap_en_i,
  input  logic [15:0]        dns_port_i,
  output logic               ev_valid_o,
  output logic               ev_two_o,
  output wihp_pkg::ev_t      ev_o,
  output wihp_pkg::summary_t sum_o
);
  import wihp_pkg::*;

  localparam int IdxW = $clog2(MaxFrameBytes + 1);

  logic [IdxW-1:0] idx_q;
  logic [15:0] fc_q;
  logic        drop_q;
  logic [15:0] eth_q;
  logic [5:0]  ihl_q;
  logic [47:0] smac_q, dmac_q;
  logic [31:0] sip_q, dip_q;
  logic [15:0] sport_q, dport_q, qtype_q;
  logic [7:0]  flags_q, proto_q;
  phase_e      ph_q;
  logic [5:0]  rem_q;
  logic        qr_q, hit_q, qv_q;

  logic [15:0] p;
  logic [4:0]  h;
  logic [15:0] rel, u, len, t;
  logic        take, in_hdr, ip_ok;
  logic        emit;
  logic [7:0]  ch;
  logic [3:0]  v;

  always_comb begin
    p = 16'(idx_q);
    h = hdr_len(fc_q);
    rel = p - 16'(h);
    u = rel - 16'd8 - 16'(ihl_q);
    take = (p < 16'(MaxFrameBytes)) && !drop_q;
    in_hdr = (p >= 16'd2) && (p >= 16'(h));
    ip_ok = in_hdr && (rel >= 16'd28) && (rel >= 16'd8 + 16'(ihl_q));
  end

  // Name character output: a byte yields a dot or a character only in the length and character phases of the walk.
  always_comb begin
    emit = 1'b0;
    ch = data_byte_i;
    if (take && ip_ok && (ph_q == PhLen) && data_byte_i != 8'd0) begin
      emit = 1'b1;
      ch = DotChar;
    end else if (take && ip_ok && ph_q == PhChars) begin
      emit = 1'b1;
    end
  end

  // Next frame state from the state as it stands before this byte plus this byte; the summary verdict uses it.
  logic [15:0] len_n;
  logic [7:0]  proto_n;
  logic        hit_n, qr_n, drop_n, qv_n;
  logic [15:0] qtype_n, sport_n, dport_n;
  logic [7:0]  flags_n;
  logic [31:0] sip_n, dip_n;
  logic [47:0] smac_n, dmac_n;
  logic [15:0] fc_n;
  logic [5:0]  ihl_n;
  logic [15:0] eth_n;
  phase_e      ph_n;
  logic [5:0]  rem_n;

  always_comb begin
    fc_n = fc_q; drop_n = drop_q; eth_n = eth_q; ihl_n = ihl_q;
    smac_n = smac_q; dmac_n = dmac_q; sip_n = sip_q; dip_n = dip_q;
    sport_n = sport_q; dport_n = dport_q; flags_n = flags_q; proto_n = proto_q;
    ph_n = ph_q; rem_n = rem_q; qr_n = qr_q; hit_n = hit_q; qv_n = qv_q;
    qtype_n = qtype_q;
    if (take) begin
      if (p == 16'd0) begin
        fc_n = {8'd0, data_byte_i};
        if (!cap_en_i || !is_data_frame_i) drop_n = 1'b1;
      end else if (p == 16'd1) begin
        fc_n = {data_byte_i, fc_q[7:0]};
        if (hdr_len({data_byte_i, fc_q[7:0]}) == 5'd0) drop_n = 1'b1;
      end else begin
        if (p >= 16'd4 && p <= 16'd9) dmac_n = {dmac_q[39:0], data_byte_i};
        if (p >= 16'd10 && p <= 16'd15) smac_n = {smac_q[39:0], data_byte_i};
        if (in_hdr) begin
          if (rel <= 16'd1) begin
            if (data_byte_i != LlcSap) drop_n = 1'b1;
          end else if (rel == 16'd2) begin
            if (data_byte_i != LlcCtrl) drop_n = 1'b1;
          end else if (rel == 16'd6) eth_n = {data_byte_i, 8'd0};
          else if (rel == 16'd7) begin
            eth_n = {eth_q[15:8], data_byte_i};
            if ({eth_q[15:8], data_byte_i} != EtherIpv4) drop_n = 1'b1;
          end else if (rel == 16'd8) begin
            ihl_n = {data_byte_i[3:0], 2'b00};
            if ({data_byte_i[3:0], 2'b00} < 6'd20) drop_n = 1'b1;
          end else if (rel == 16'd17) proto_n = data_byte_i;
          else if (rel >= 16'd20 && rel <= 16'd23) sip_n = {sip_q[23:0], data_byte_i};
          else if (rel >= 16'd24 && rel <= 16'd27) dip_n = {dip_q[23:0], data_byte_i};
          if (!drop_n && ip_ok) begin
            if (u <= 16'd1) sport_n = {sport_q[7:0], data_byte_i};
            else if (u <= 16'd3) dport_n = {dport_q[7:0], data_byte_i};
            if (u == 16'd3)
              hit_n = (proto_q == ProtoUdp) &&
                      (sport_q == dns_port_i || {dport_q[7:0], data_byte_i} == dns_port_i);
            if (u == 16'd13) flags_n = data_byte_i;
            if (u == 16'd10) qr_n = data_byte_i[7];
            if (u == 16'd20 && hit_q && !qr_q) ph_n = PhFirst;
            unique case (ph_n)
              PhFirst, PhLen: begin
                if (data_byte_i == 8'd0) ph_n = PhQhi;
                else if (data_byte_i >= 8'd64) ph_n = PhDone;
                else begin
                  ph_n = PhChars;
                  rem_n = data_byte_i[5:0];
                end
              end
              PhChars: begin
                rem_n = rem_q - 6'd1;
                if (rem_q == 6'd1) ph_n = PhLen;
              end
              PhQhi: begin
                qtype_n = {data_byte_i, 8'd0};
                ph_n = PhQlo;
              end
              PhQlo: begin
                qtype_n = {qtype_q[15:8], data_byte_i};
                qv_n = 1'b1;
                ph_n = PhDone;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    len = (p < 16'(MaxFrameBytes)) ? p + 16'd1 : p;
    t = 16'(hdr_len(fc_n)) + 16'd8 + 16'(ihl_n);
    if (proto_n == ProtoUdp) begin
      if (len < t + 16'd8) v = VerdictUdpShort;
      else if (hit_n) v = (!qr_n && len >= t + 16'd21) ? VerdictDnsQuery : VerdictDns;
      else v = VerdictUdp;
    end else if (proto_n == ProtoTcp) v = (len >= t + 16'd20) ? VerdictTcp : VerdictTcpShort;
    else if (proto_n == ProtoIcmp) v = VerdictIcmp;
    else v = VerdictOtherIp;
    if (drop_n || len < 16'd2 || hdr_len(fc_n) == 5'd0 ||
        len < 16'(hdr_len(fc_n)) + 16'd28) v = VerdictDrop;
  end

  always_comb begin
    sum_o = '0;
    sum_o.verdict = v;
    if (v != VerdictDrop) begin
      sum_o.ip_protocol = proto_n;
      sum_o.source_ip = sip_n;
      sum_o.dest_ip = dip_n;
      sum_o.source_mac = smac_n;
      sum_o.dest_mac = dmac_n;
      if (v == VerdictUdp || v == VerdictDns || v == VerdictDnsQuery || v == VerdictTcp) begin
        sum_o.source_port = sport_n;
        sum_o.dest_port = dport_n;
      end
      if (v == VerdictTcp) sum_o.tcp_flag_bits = flags_n;
      if (v == VerdictDnsQuery && qv_n) sum_o.query_type = qtype_n;
    end
  end

  always_comb begin
    ev_valid_o = in_fire_i && (emit || last_byte_i);
    ev_two_o = emit && last_byte_i;
    ev_o.is_char = emit;
    ev_o.name_char = ch;
    ev_o.is_summary = last_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; fc_q <= '0; drop_q <= 1'b0; eth_q <= '0; ihl_q <= '0;
      smac_q <= '0; dmac_q <= '0; sip_q <= '0; dip_q <= '0;
      sport_q <= '0; dport_q <= '0; flags_q <= '0; proto_q <= '0;
      ph_q <= PhIdle; rem_q <= '0; qr_q <= 1'b0; hit_q <= 1'b0; qv_q <= 1'b0;
      qtype_q <= '0;
    end else if (in_fire_i) begin
      if (last_byte_i) begin
        idx_q <= '0; fc_q <= '0; drop_q <= 1'b0; eth_q <= '0; ihl_q <= '0;
        smac_q <= '0; dmac_q <= '0; sip_q <= '0; dip_q <= '0;
        sport_q <= '0; dport_q <= '0; flags_q <= '0; proto_q <= '0;
        ph_q <= PhIdle; rem_q <= '0; qr_q <= 1'b0; hit_q <= 1'b0; qv_q <= 1'b0;
        qtype_q <= '0;
      end else begin
        if (p < 16'(MaxFrameBytes)) idx_q <= idx_q + 1'b1;
        fc_q <= fc_n; drop_q <= drop_n; eth_q <= eth_n; ihl_q <= ihl_n;
        smac_q <= smac_n; dmac_q <= dmac_n; sip_q <= sip_n; dip_q <= dip_n;
        sport_q <= sport_n; dport_q <= dport_n; flags_q <= flags_n;
        proto_q <= proto_n; ph_q <= ph_n; rem_q <= rem_n; qr_q <= qr_n;
        hit_q <= hit_n; qv_q <= qv_n; qtype_q <= qtype_n;
      end
    end
  end

endmodule

/* design/wihp_back.sv */
// Back end: a four-entry item queue feeding the output channel.
module wihp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ev_valid_i,
  input  logic               ev_two_i,
  input  wihp_pkg::ev_t      ev_i,
  input  wihp_pkg::summary_t sum_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               item_kind_o,
  output logic [7:0]         name_char_o,
  output wihp_pkg::summary_t sum_o
);
  import wihp_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    summary_t   s;
  } ent_t;

  ent_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] nps;
  ent_t       a, b;

  always_comb begin
    a = '0;
    b = '0;
    a.kind = !ev_i.is_char;
    a.ch = ev_i.is_char ? ev_i.name_char : 8'd0;
    if (!ev_i.is_char) a.s = sum_i;
    b.kind = 1'b1;
    b.s = sum_i;
    nps = ev_valid_i ? (ev_two_i ? 2'd2 : 2'd1) : 2'd0;
    pop = out_ready_i && (cnt_q != 3'd0);
  end

  // Room for two is demanded so a byte producing two items never overflows.
  assign room_o = cnt_q <= 3'd2;
  assign out_valid_o = cnt_q != 3'd0;
  assign item_kind_o = mem_q[rd_q].kind;
  assign name_char_o = mem_q[rd_q].ch;
  assign sum_o = mem_q[rd_q].s;

  always_ff @(posedge clk_i) begin
    if (nps != 2'd0) mem_q[wr_q] <= a;
    if (nps == 2'd2) mem_q[wr_q + 2'd1] <= b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_q + nps;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(nps) - 3'(pop);
    end
  end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the byte-serial 802.11 IPv4 header parser.
module tb;
  import wihp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomBytes = 1850;

  typedef struct {
    logic        kind;
    logic [7:0]  name_char;
    logic [3:0]  verdict;
    logic [7:0]  ip_protocol;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] query_type;
  } parse_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        is_data_frame_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        item_kind_o;
  logic [7:0]  name_char_o;
  logic [3:0]  verdict_o;
  logic [7:0]  ip_protocol_o;
  logic [31:0] source_ip_o;
  logic [31:0] dest_ip_o;
  logic [47:0] source_mac_o;
  logic [47:0] dest_mac_o;
  logic [15:0] source_port_o;
  logic [15:0] dest_port_o;
  logic [7:0]  tcp_flag_bits_o;
  logic [15:0] query_type_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  wlan_ipv4_header_parser_top DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: configuration and the frame being parsed.
  logic        pr_capture;
  logic [15:0] pr_dns_port;
  int unsigned pr_idx;
  logic [15:0] pr_fc;
  logic        pr_drop;
  logic [15:0] pr_ether;
  int unsigned pr_ihl;
  logic [47:0] pr_smac, pr_dmac;
  logic [31:0] pr_sip, pr_dip;
  logic [15:0] pr_sport, pr_dport;
  logic [7:0]  pr_flags, pr_proto;
  phase_e      pr_phase;
  logic [5:0]  pr_rem;
  logic [15:0] pr_qtype;
  logic        pr_qr, pr_hit, pr_qvalid;

  parse_result_t expected_q[$];
  logic [7:0]    frame_q[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   frames_sent = 0;
  int unsigned   chars_seen = 0;
  int unsigned   summaries_seen = 0;
  bit            quiet = 1'b0;

  function automatic int unsigned mac_header_len(input logic [15:0] fc);
    if (fc[3:2] != 2'd2) return 0;
    if (fc[7:4] == 4'd0 || fc[7:4] == 4'd4) return 24;
    if (fc[7]) return 26;
    return 0;
  endfunction

  task automatic add_frame_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  task automatic add_expected(input parse_result_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic clear_frame_state();
    pr_idx = 0; pr_fc = '0; pr_drop = 1'b0; pr_ether = '0; pr_ihl = 0;
    pr_smac = '0; pr_dmac = '0; pr_sip = '0; pr_dip = '0;
    pr_sport = '0; pr_dport = '0; pr_flags = '0; pr_proto = '0;
    pr_phase = PhIdle; pr_rem = '0; pr_qtype = '0;
    pr_qr = 1'b0; pr_hit = 1'b0; pr_qvalid = 1'b0;
  endtask

  task automatic push_char(input logic [7:0] c);
    parse_result_t r;
    r = '{default: '0};
    r.name_char = c;
    add_expected(r);
  endtask

  task automatic walk_query_name(input logic [7:0] b);
    if (pr_phase == PhFirst || pr_phase == PhLen) begin
      if (pr_phase == PhLen && b != 8'd0) push_char(DotChar);
      if (b == 8'd0) pr_phase = PhQhi;
      else if (b >= 8'd64) pr_phase = PhDone;
      else begin
        pr_phase = PhChars;
        pr_rem = b[5:0];
      end
    end else if (pr_phase == PhChars) begin
      push_char(b);
      pr_rem = pr_rem - 6'd1;
      if (pr_rem == 6'd0) pr_phase = PhLen;
    end else if (pr_phase == PhQhi) begin
      pr_qtype = {b, 8'h00};
      pr_phase = PhQlo;
    end else if (pr_phase == PhQlo) begin
      pr_qtype[7:0] = b;
      pr_qvalid = 1'b1;
      pr_phase = PhDone;
    end
  endtask

  task automatic parse_byte(input int unsigned p, input logic [7:0] b, input logic tag);
    int unsigned h, rel, u;
    if (p == 0) begin
      pr_fc = {8'h00, b};
      if (!pr_capture || !tag) pr_drop = 1'b1;
      return;
    end
    if (p == 1) begin
      pr_fc[15:8] = b;
      if (mac_header_len(pr_fc) == 0) pr_drop = 1'b1;
      return;
    end
    if (p >= 4 && p <= 9) pr_dmac = {pr_dmac[39:0], b};
    if (p >= 10 && p <= 15) pr_smac = {pr_smac[39:0], b};
    h = mac_header_len(pr_fc);
    if (p < h) return;
    rel = p - h;
    if (rel <= 1) begin
      if (b != LlcSap) pr_drop = 1'b1;
    end else if (rel == 2) begin
      if (b != LlcCtrl) pr_drop = 1'b1;
    end else if (rel == 6) pr_ether = {b, 8'h00};
    else if (rel == 7) begin
      pr_ether[7:0] = b;
      if (pr_ether != EtherIpv4) pr_drop = 1'b1;
    end else if (rel == 8) begin
      pr_ihl = b[3:0] * 4;
      if (pr_ihl < 20) pr_drop = 1'b1;
    end else if (rel == 17) pr_proto = b;
    else if (rel >= 20 && rel <= 23) pr_sip = {pr_sip[23:0], b};
    else if (rel >= 24 && rel <= 27) pr_dip = {pr_dip[23:0], b};
    if (pr_drop || rel < 28 || rel < 8 + pr_ihl) return;
    u = rel - 8 - pr_ihl;
    if (u <= 1) pr_sport = {pr_sport[7:0], b};
    else if (u <= 3) pr_dport = {pr_dport[7:0], b};
    if (u == 3)
      pr_hit = (pr_proto == ProtoUdp) && (pr_sport == pr_dns_port || pr_dport == pr_dns_port);
    if (u == 13) pr_flags = b;
    if (u == 10) pr_qr = b[7];
    if (u == 20 && pr_hit && !pr_qr) pr_phase = PhFirst;
    if (pr_phase != PhIdle && pr_phase != PhDone) walk_query_name(b);
  endtask

  task automatic emit_summary();
    parse_result_t r;
    int unsigned h, t;
    logic [3:0] v;
    r = '{default: '0};
    r.kind = 1'b1;
    h = mac_header_len(pr_fc);
    if (!(pr_drop || pr_idx < 2 || h == 0 || pr_idx < h + 28)) begin
      t = h + 8 + pr_ihl;
      if (pr_proto == ProtoUdp) begin
        if (pr_idx < t + 8) v = VerdictUdpShort;
        else if (pr_hit) v = (!pr_qr && pr_idx >= t + 21) ? VerdictDnsQuery : VerdictDns;
        else v = VerdictUdp;
      end else if (pr_proto == ProtoTcp) v = (pr_idx >= t + 20) ? VerdictTcp : VerdictTcpShort;
      else if (pr_proto == ProtoIcmp) v = VerdictIcmp;
      else v = VerdictOtherIp;
      r.verdict = v;
      r.ip_protocol = pr_proto;
      r.source_ip = pr_sip;
      r.dest_ip = pr_dip;
      r.source_mac = pr_smac;
      r.dest_mac = pr_dmac;
      if (v inside {VerdictUdp, VerdictDns, VerdictDnsQuery, VerdictTcp}) begin
        r.source_port = pr_sport;
        r.dest_port = pr_dport;
      end
      if (v == VerdictTcp) r.tcp_flag_bits = pr_flags;
      if (v == VerdictDnsQuery && pr_qvalid) r.query_type = pr_qtype;
    end
    add_expected(r);
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last, input logic tag);
    int unsigned p;
    p = pr_idx;
    if (p < MaxFrameBytesDef) begin
      if (!pr_drop) parse_byte(p, b, tag);
      pr_idx = p + 1;
    end
    if (last) begin
      emit_summary();
      clear_frame_state();
    end
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
             cycle_count, field, got, want);
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    parse_result_t e;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("wlan_ipv4_header_parser_top regression: fail");
      $finish;
    end else if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, kind", 64'(item_kind_o), 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (item_kind_o) summaries_seen++;
        else chars_seen++;
        check_field("item_kind", 64'(item_kind_o), 64'(e.kind));
        check_field("name_char", 64'(name_char_o), 64'(e.name_char));
        check_field("verdict", 64'(verdict_o), 64'(e.verdict));
        check_field("ip_protocol", 64'(ip_protocol_o), 64'(e.ip_protocol));
        check_field("source_ip", 64'(source_ip_o), 64'(e.source_ip));
        check_field("dest_ip", 64'(dest_ip_o), 64'(e.dest_ip));
        check_field("source_mac", 64'(source_mac_o), 64'(e.source_mac));
        check_field("dest_mac", 64'(dest_mac_o), 64'(e.dest_mac));
        check_field("source_port", 64'(source_port_o), 64'(e.source_port));
        check_field("dest_port", 64'(dest_port_o), 64'(e.dest_port));
        check_field("tcp_flag_bits", 64'(tcp_flag_bits_o), 64'(e.tcp_flag_bits));
        check_field("query_type", 64'(query_type_o), 64'(e.query_type));
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic tag);
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 34) begin
      in_valid_i = 1'b0;
      while ($urandom_range(99) < 34) @(negedge clk_i);
      @(negedge clk_i);
    end
    data_byte_i = b;
    last_byte_i = last;
    is_data_frame_i = tag;
    in_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    predict_byte(b, last, tag);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic tag);
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1, (i == 0) ? tag : 1'($urandom));
    frames_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    // A frame still inside the block may yet produce nothing; give it time to settle.
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = value;
    cfg_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    if (idx == CfgCaptureEnable) pr_capture = value[0];
    else pr_dns_port = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Shapes of the transport payload built after the IPv4 header.
  localparam int ShapeRaw = 0;
  localparam int ShapeQuery = 1;
  localparam int ShapeResponse = 2;
  localparam int ShapeLongLabel = 3;

  task automatic build_frame(input logic [3:0] sub, input logic [7:0] proto, input int ihl,
                             input int shape, input int tail);
    int h, labels, len;
    frame_q.delete();
    add_frame_byte({sub, 2'b10, 2'b00});
    add_frame_byte(8'($urandom));
    h = sub[3] ? 26 : 24;
    while (frame_q.size() < h) add_frame_byte(8'($urandom));
    add_frame_byte(LlcSap);
    add_frame_byte(LlcSap);
    add_frame_byte(LlcCtrl);
    repeat (3) add_frame_byte(8'($urandom));
    add_frame_byte(EtherIpv4[15:8]);
    add_frame_byte(EtherIpv4[7:0]);
    add_frame_byte({4'h4, 4'(ihl)});
    repeat (8) add_frame_byte(8'($urandom));
    add_frame_byte(proto);
    repeat (10) add_frame_byte(8'($urandom));
    for (int i = 20; i < ihl * 4; i++) add_frame_byte(8'($urandom));
    if (shape != ShapeRaw) begin
      if ($urandom_range(1)) begin
        add_frame_byte(pr_dns_port[15:8]); add_frame_byte(pr_dns_port[7:0]);
        repeat (2) add_frame_byte(8'($urandom));
      end else begin
        repeat (2) add_frame_byte(8'($urandom));
        add_frame_byte(pr_dns_port[15:8]); add_frame_byte(pr_dns_port[7:0]);
      end
      repeat (6) add_frame_byte(8'($urandom));
      add_frame_byte({shape == ShapeResponse, 7'($urandom)});
      repeat (9) add_frame_byte(8'($urandom));
      labels = $urandom_range(1, 4);
      for (int l = 0; l < labels; l++) begin
        len = $urandom_range(1, 8);
        add_frame_byte(8'(len));
        repeat (len) add_frame_byte(8'($urandom));
      end
      add_frame_byte(shape == ShapeLongLabel ? 8'($urandom_range(64, 255)) : 8'h00);
      repeat (2) add_frame_byte(8'($urandom));
    end
    repeat (tail) add_frame_byte(8'($urandom));
  endtask

  task automatic truncate_frame(input int n);
    while (frame_q.size() > n && frame_q.size() > 1) void'(frame_q.pop_back());
  endtask

  task automatic test_registers();
    write_reg(CfgCaptureEnable, 16'd0);
    build_frame(4'd0, ProtoUdp, 5, ShapeQuery, 4);
    send_frame(1'b1);
    drain();
    write_reg(CfgCaptureEnable, 16'hffff);
    write_reg(CfgDnsPort, DnsPortReset);
  endtask

  task automatic test_header_forms();
    build_frame(4'd0, ProtoIcmp, 5, ShapeRaw, 8); send_frame(1'b1);
    build_frame(4'd4, ProtoIcmp, 5, ShapeRaw, 8); send_frame(1'b1);
    build_frame(4'd8, ProtoIcmp, 5, ShapeRaw, 8); send_frame(1'b1);
    build_frame(4'd15, ProtoIcmp, 5, ShapeRaw, 8); send_frame(1'b1);
    build_frame(4'd1, ProtoIcmp, 5, ShapeRaw, 8); send_frame(1'b1);
    build_frame(4'd0, ProtoIcmp, 5, ShapeRaw, 8);
    frame_q[0][3:2] = 2'd0;
    send_frame(1'b1);
    build_frame(4'd0, ProtoIcmp, 5, ShapeRaw, 8); send_frame(1'b0);
    build_frame(4'd0, ProtoIcmp, 5, ShapeRaw, 8);
    frame_q[26] = 8'h04;
    send_frame(1'b1);
    build_frame(4'd0, ProtoIcmp, 5, ShapeRaw, 8);
    frame_q[31] = 8'h06;
    send_frame(1'b1);
    build_frame(4'd0, ProtoIcmp, 4, ShapeRaw, 16); send_frame(1'b1);
    frame_q.delete(); add_frame_byte(8'h08); send_frame(1'b1);
    build_frame(4'd0, ProtoIcmp, 5, ShapeRaw, 0); truncate_frame(51); send_frame(1'b1);
    build_frame(4'd0, ProtoIcmp, 5, ShapeRaw, 0); truncate_frame(52); send_frame(1'b1);
    drain();
  endtask

  task automatic test_protocols();
    build_frame(4'd8, 8'd47, 6, ShapeRaw, 3); send_frame(1'b1);
    build_frame(4'd0, ProtoUdp, 5, ShapeRaw, 7); send_frame(1'b1);
    build_frame(4'd0, ProtoUdp, 5, ShapeRaw, 12); send_frame(1'b1);
    build_frame(4'd0, ProtoUdp, 5, ShapeResponse, 2); send_frame(1'b1);
    build_frame(4'd4, ProtoUdp, 7, ShapeQuery, 3); send_frame(1'b1);
    build_frame(4'd0, ProtoUdp, 5, ShapeQuery, 0); truncate_frame(24 + 28 + 20); send_frame(1'b1);
    build_frame(4'd9, ProtoUdp, 5, ShapeLongLabel, 2); send_frame(1'b1);
    build_frame(4'd0, ProtoUdp, 5, ShapeQuery, 0); truncate_frame(24 + 28 + 24); send_frame(1'b1);
    build_frame(4'd0, ProtoUdp, 5, ShapeQuery, 0); truncate_frame(frame_q.size() - 1);
    send_frame(1'b1);
    build_frame(4'd0, ProtoTcp, 5, ShapeRaw, 19); send_frame(1'b1);
    build_frame(4'd12, ProtoTcp, 15, ShapeRaw, 24); send_frame(1'b1);
    drain();
  endtask

  task automatic test_random();
    int pick;
    logic [3:0] sub;
    logic [7:0] proto;
    int frame_no;
    frame_no = 0;
    while (bytes_sent < RandomBytes) begin
      if (frame_no % 8 == 7) begin
        drain();
        pick = $urandom_range(9);
        write_reg(CfgCaptureEnable, pick == 0 ? 16'd0 : 16'd1);
        pick = $urandom_range(3);
        write_reg(CfgDnsPort, pick == 0 ? 16'd0 : pick == 1 ? 16'hffff :
                              pick == 2 ? DnsPortReset : 16'($urandom));
      end
      quiet = (frame_no < 2);
      pick = $urandom_range(5);
      sub = (pick < 2) ? 4'd0 : (pick < 3) ? 4'd4 : 4'($urandom_range(8, 15));
      pick = $urandom_range(9);
      proto = (pick < 5) ? ProtoUdp : (pick < 8) ? ProtoTcp : (pick < 9) ? ProtoIcmp :
              8'($urandom);
      build_frame(sub, proto, $urandom_range(5, 8),
                  (proto == ProtoUdp && $urandom_range(9) < 6) ?
                  ($urandom_range(9) < 7 ? ShapeQuery : $urandom_range(2, 3)) : ShapeRaw,
                  $urandom_range(0, 24));
      pick = $urandom_range(9);
      if (pick == 0) truncate_frame($urandom_range(1, frame_q.size()));
      else if (pick == 1) frame_q[$urandom_range(0, 40)] = 8'($urandom);
      else if (pick == 2) begin
        frame_q.delete();
        repeat ($urandom_range(1, 60)) add_frame_byte(8'($urandom));
      end
      send_frame(pick == 3 ? 1'($urandom) : 1'b1);
      frame_no++;
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    pr_capture = 1'b0;
    pr_dns_port = DnsPortReset;
    clear_frame_state();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_registers();
    test_header_forms();
    test_protocols();
    test_random();
    $display("covered %0d frames, %0d bytes: %0d summaries and %0d name characters checked",
             frames_sent, bytes_sent, summaries_seen, chars_seen);
    if (error_count == 0) begin
      $display("wlan_ipv4_header_parser_top regression: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("wlan_ipv4_header_parser_top regression: fail");
    end
    $finish;
  end

endmodule
